FILE: hw/rtl/csp_pkg.sv
// Shared types for the counting semaphore pool: operation codes and result status.
// No dependencies.
`timescale 1ns / 1ps

package csp_pkg;

  typedef enum logic [2:0] {
    OpWait    = 3'd0,
    OpPost    = 3'd1,
    OpOpen    = 3'd2,
    OpClose   = 3'd3,
    OpInit    = 3'd4,
    OpDestroy = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusUnused = 2'd1,
    StatusFull   = 2'd2
  } status_e;

  localparam int unsigned CountW = 16;
  localparam int unsigned RefsW  = 8;
  localparam int unsigned TidW   = 6;
  localparam int unsigned IdxW   = 4;

endpackage

FILE: hw/rtl/counting_semaphore_pool_top.sv
// Top level of the counting semaphore pool: state memory, wait-queue memory and control.
// Depends on csp_pkg and csp_ram.
`timescale 1ns / 1ps

// Pool of counting semaphores with a FIFO of waiting thread ids per semaphore.
// An operation is taken when start_i is high and busy_o is low. The semaphore's
// entry is read from the state memory in the accept cycle, modified and written
// back in the next cycle, during which busy_o is high; the result appears on the
// following cycle with done_o high for exactly one cycle. Only one operation is
// in flight at a time, set by the read-modify-write of the single state memory,
// and a new one may be started in the cycle its result is shown. The receiver
// cannot stall: it must take the word whenever done_o is high.
module counting_semaphore_pool_top #(
  parameter int unsigned NUM_SEMS    = 16,
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned THREAD_BITS = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [2:0]              op_i,
  input  logic [3:0]              sem_index_i,
  input  logic [5:0]              thread_id_i,
  input  logic [15:0]             init_value_i,
  output logic                    done_o,
  output csp_pkg::status_e        status_o,
  output logic                    blocked_o,
  output logic                    woken_valid_o,
  output logic [5:0]              woken_thread_o,
  output logic [15:0]             count_after_o
);

  import csp_pkg::*;

  localparam int unsigned SemAw   = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int unsigned QAw     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FillW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned WDepth  = NUM_SEMS * QUEUE_DEPTH;
  localparam int unsigned WAw     = (WDepth > 1) ? $clog2(WDepth) : 1;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              in_use;
    logic [RefsW-1:0]  refs;
    logic [QAw-1:0]    head;
    logic [QAw-1:0]    tail;
    logic [FillW-1:0]  fill;
  } sem_entry_t;

  localparam int unsigned EntryW = $bits(sem_entry_t);

  typedef enum logic {
    StIdle,
    StCalc
  } state_e;

  state_e state_q;

  // captured operation
  logic [2:0]        op_q;
  logic [IdxW-1:0]   idx_q;
  logic [TidW-1:0]   tid_q;
  logic [CountW-1:0] ival_q;
  logic              rd_valid_q;

  logic [NUM_SEMS-1:0] valid_q;

  logic done_q, blocked_q, wvalid_q;
  status_e status_q;
  logic [CountW-1:0] count_q;

  logic accept;
  logic in_range_in, in_range;
  logic [SemAw+IdxW-1:0] idx_in_ext, idx_ext;
  logic [SemAw-1:0] addr_in, addr;

  logic [EntryW-1:0] sem_rdata;
  sem_entry_t cur, nxt;
  logic sem_we;

  logic wait_we, wait_re;
  logic [WAw-1:0] wait_waddr, wait_raddr;
  logic [THREAD_BITS-1:0] wait_rdata, tid_store;
  logic [TidW-1:0] tid_masked;

  status_e status_d;
  logic blocked_d, wvalid_d;
  logic [CountW-1:0] count_d;

  assign accept = start_i && (state_q == StIdle);
  assign busy_o = (state_q != StIdle);

  assign idx_in_ext  = {{SemAw{1'b0}}, sem_index_i};
  assign addr_in     = idx_in_ext[SemAw-1:0];
  assign in_range_in = (32'(sem_index_i) < NUM_SEMS);

  assign idx_ext  = {{SemAw{1'b0}}, idx_q};
  assign addr     = idx_ext[SemAw-1:0];
  assign in_range = (32'(idx_q) < NUM_SEMS);

  csp_ram #(
    .Width (EntryW),
    .Depth (NUM_SEMS)
  ) u_sem_ram (
    .clk_i   (clk_i),
    .we_i    (sem_we),
    .waddr_i (addr),
    .wdata_i (nxt),
    .re_i    (accept),
    .raddr_i (addr_in),
    .rdata_o (sem_rdata)
  );

  csp_ram #(
    .Width (THREAD_BITS),
    .Depth (WDepth)
  ) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (wait_we),
    .waddr_i (wait_waddr),
    .wdata_i (tid_store),
    .re_i    (wait_re),
    .raddr_i (wait_raddr),
    .rdata_o (wait_rdata)
  );

  function automatic logic [QAw-1:0] next_slot(input logic [QAw-1:0] p);
    next_slot = (p == QAw'(QUEUE_DEPTH - 1)) ? '0 : p + QAw'(1);
  endfunction

  assign tid_masked = tid_q & TidW'((33'd1 << THREAD_BITS) - 33'd1);
  assign tid_store  = THREAD_BITS'(tid_masked);

  // entry not yet written reads as its reset value
  assign cur = rd_valid_q ? sem_entry_t'(sem_rdata) : '0;

  assign wait_waddr = WAw'(32'(addr) * QUEUE_DEPTH + 32'(cur.tail));
  assign wait_raddr = WAw'(32'(addr) * QUEUE_DEPTH + 32'(cur.head));

  always_comb begin
    nxt       = cur;
    status_d  = StatusOk;
    blocked_d = 1'b0;
    wvalid_d  = 1'b0;
    wait_we   = 1'b0;
    wait_re   = 1'b0;
    sem_we    = 1'b0;
    count_d   = '0;
    if (state_q == StCalc) begin
      if (!in_range) begin
        status_d = StatusUnused;
      end else begin
        sem_we = 1'b1;
        case (op_e'(op_q))
          OpWait: begin
            if (!cur.in_use) begin
              status_d = StatusUnused;
            end else if (cur.count != '0) begin
              nxt.count = cur.count - CountW'(1);
            end else if (cur.fill == FillW'(QUEUE_DEPTH)) begin
              status_d = StatusFull;
            end else begin
              wait_we   = 1'b1;
              nxt.tail  = next_slot(cur.tail);
              nxt.fill  = cur.fill + FillW'(1);
              blocked_d = 1'b1;
            end
          end
          OpPost: begin
            if (!cur.in_use) begin
              status_d = StatusUnused;
            end else if ((cur.count != '0) || (cur.fill == '0)) begin
              if (cur.count != '1) begin
                nxt.count = cur.count + CountW'(1);
              end
            end else begin
              wait_re  = 1'b1;
              wvalid_d = 1'b1;
              nxt.head = next_slot(cur.head);
              nxt.fill = cur.fill - FillW'(1);
            end
          end
          OpOpen: begin
            nxt.in_use = 1'b1;
            if (cur.refs != '1) begin
              nxt.refs = cur.refs + RefsW'(1);
            end
            nxt.count = ival_q;
          end
          OpClose: begin
            if (cur.in_use) begin
              if (cur.refs != '0) begin
                nxt.refs = cur.refs - RefsW'(1);
              end
              if (nxt.refs == '0) begin
                nxt.in_use = 1'b0;
              end
            end
          end
          OpInit: begin
            nxt.count  = ival_q;
            nxt.head   = '0;
            nxt.tail   = '0;
            nxt.fill   = '0;
            nxt.in_use = 1'b1;
          end
          OpDestroy: begin
            nxt.in_use = 1'b0;
            nxt.head   = '0;
            nxt.tail   = '0;
            nxt.fill   = '0;
            nxt.count  = '0;
          end
          default: begin
          end
        endcase
        count_d = nxt.count;
      end
    end
  end

  // hold the operation while the entry is read back
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      idx_q  <= sem_index_i;
      tid_q  <= thread_id_i;
      ival_q <= init_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      done_q     <= 1'b0;
      status_q   <= StatusOk;
      blocked_q  <= 1'b0;
      wvalid_q   <= 1'b0;
      count_q    <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          done_q <= 1'b0;
          if (accept) begin
            rd_valid_q <= in_range_in ? valid_q[addr_in] : 1'b0;
            state_q    <= StCalc;
          end
        end
        StCalc: begin
          if (sem_we) begin
            valid_q[addr] <= 1'b1;
          end
          done_q    <= 1'b1;
          status_q  <= status_d;
          blocked_q <= blocked_d;
          wvalid_q  <= wvalid_d;
          count_q   <= count_d;
          state_q   <= StIdle;
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign blocked_o      = blocked_q;
  assign woken_valid_o  = wvalid_q;
  assign woken_thread_o = wvalid_q ? TidW'(wait_rdata) : '0;
  assign count_after_o  = count_q;

endmodule

FILE: hw/rtl/csp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module csp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
